/* rtl/psw_pkg.sv */
`default_nettype none
package psw_pkg;

  localparam int unsigned WORD_W      = 32;
  localparam int unsigned DUR_W       = 45;
  localparam int unsigned HOLD_W      = 32;
  localparam int unsigned FRAC_W      = 8;
  localparam int unsigned ERR_W       = 24;
  localparam int unsigned REQ_W       = 48;
  localparam int unsigned PIN_W       = 5;
  localparam int unsigned MAP_REG_W   = 40;
  localparam int unsigned MAP_REGS    = 4;
  localparam int unsigned MAP_PER_REG = 8;
  localparam int unsigned PADDR_W     = 5;
  localparam int unsigned PDATA_W     = 64;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = 1;

  // Q40.8 tick constants on the signed request path
  localparam logic signed [REQ_W-1:0] FULL_LIMIT_Q = 48'sh00FF_FFFF_FF00;
  localparam logic signed [REQ_W-1:0] FULL_COST_Q  = 48'sh0100_0000_0200;
  localparam logic signed [REQ_W-1:0] ROUND_OFS_Q  = 48'sd640;
  localparam logic signed [REQ_W-1:0] HALF_Q       = 48'sd128;
  localparam logic signed [REQ_W-1:0] ERR_MIN_Q    = -48'sd8388608;

  typedef struct packed {
    logic [WORD_W-1:0] word;
    logic [DUR_W-1:0]  duration;
    logic              restart;
    logic              eob;
  } psw_item_t;

  typedef logic [MAP_REGS-1:0][MAP_REG_W-1:0] psw_map_t;

  // Identity mapping: logical bit n drives pin n
  function automatic logic [MAP_REG_W-1:0] map_default(input int idx);
    logic [MAP_REG_W-1:0] v;
    v = '0;
    for (int k = 0; k < MAP_PER_REG; k++) begin
      v = v | (MAP_REG_W'(idx * MAP_PER_REG + k) << (PIN_W * k));
    end
    return v;
  endfunction

endpackage
`default_nettype wire

/* rtl/psw_in_if.sv */
`default_nettype none
interface psw_in_if;
  logic                          valid;
  logic                          ready;
  logic [psw_pkg::WORD_W-1:0]    raw_word;
  logic [psw_pkg::DUR_W-1:0]     duration_ticks;
  logic                          restart;
  logic                          end_of_batch;

  modport source (output valid, raw_word, duration_ticks, restart, end_of_batch,
                  input ready);
  modport sink   (input valid, raw_word, duration_ticks, restart, end_of_batch,
                  output ready);
endinterface
`default_nettype wire

/* rtl/psw_out_if.sv */
`default_nettype none
interface psw_out_if;
  logic                          valid;
  logic                          ready;
  logic [psw_pkg::WORD_W-1:0]    pattern_word;
  logic [psw_pkg::HOLD_W-1:0]    hold_ticks;
  logic                          last_segment;
  logic                          capacity_full;

  modport source (output valid, pattern_word, hold_ticks, last_segment, capacity_full,
                  input ready);
  modport sink   (input valid, pattern_word, hold_ticks, last_segment, capacity_full,
                  output ready);
endinterface
`default_nettype wire

/* rtl/psw_front.sv */
`default_nettype none
module psw_front #(
  parameter int MAP_BITS = 32
) (
  psw_in_if.sink             in_chan,
  input  psw_pkg::psw_map_t  map_i,
  input  logic               q_full_i,
  output logic               push_o,
  output psw_pkg::psw_item_t push_item_o
);

  logic [psw_pkg::WORD_W-1:0] pin_word;

  // Logical-to-pin permutation: each set logical bit lights its mapped pin
  always_comb begin
    logic [psw_pkg::PIN_W-1:0] pin;
    pin_word = '0;
    for (int b = 0; b < psw_pkg::WORD_W; b++) begin
      pin = map_i[b >> 3][psw_pkg::PIN_W * (b & 7) +: psw_pkg::PIN_W];
      if (b < MAP_BITS && in_chan.raw_word[b]) begin
        pin_word[pin] = 1'b1;
      end
    end
  end

  assign in_chan.ready = !q_full_i;
  assign push_o        = in_chan.valid && !q_full_i;

  always_comb begin
    push_item_o.word     = pin_word;
    push_item_o.duration = in_chan.duration_ticks;
    push_item_o.restart  = in_chan.restart;
    push_item_o.eob      = in_chan.end_of_batch;
  end

endmodule
`default_nettype wire

/* rtl/psw_queue.sv */
`default_nettype none
module psw_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push_i,
  input  psw_pkg::psw_item_t push_item_i,
  output logic               full_o,
  input  logic               pop_i,
  output psw_pkg::psw_item_t head_o,
  output logic               empty_o
);

  psw_pkg::psw_item_t               entries_r [psw_pkg::QUEUE_DEPTH];
  logic [psw_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [psw_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [psw_pkg::QPTR_W:0]         cnt_r, cnt_nxt;
  logic                             do_push, do_pop;

  assign full_o  = (cnt_r == (psw_pkg::QPTR_W + 1)'(psw_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_r == '0);
  assign head_o  = entries_r[rd_ptr_r];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries_r[wr_ptr_r] <= push_item_i;
    end
  end

endmodule
`default_nettype wire

/* rtl/psw_back.sv */
`default_nettype none
module psw_back #(
  parameter int CAPACITY = 1024,
  parameter int CNT_W    = 11
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_empty_i,
  input  psw_pkg::psw_item_t head_i,
  output logic               pop_o,
  psw_out_if.source          out_chan
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_RUN  = 1'b1;
  localparam int   REQ_W   = psw_pkg::REQ_W;
  localparam int   ERR_W   = psw_pkg::ERR_W;

  logic                              state_r, state_nxt;
  logic signed [ERR_W-1:0]           err_r, err_nxt;
  logic [CNT_W-1:0]                  wc_r, wc_nxt;
  logic [CNT_W-1:0]                  committed_r, committed_nxt;
  logic                              aborted_r, aborted_nxt;
  logic signed [REQ_W-1:0]           req_r, req_nxt;
  logic [psw_pkg::WORD_W-1:0]        word_r, word_nxt;
  logic                              eob_r, eob_nxt;

  logic                              out_valid_r;
  logic [psw_pkg::WORD_W-1:0]        out_word_r;
  logic [psw_pkg::HOLD_W-1:0]        out_hold_r;
  logic                              out_last_r, out_full_r;
  logic                              load_out;
  logic [psw_pkg::HOLD_W-1:0]        o_hold;
  logic                              o_last, o_full;

  logic                              out_free, at_cap, is_long;
  logic signed [ERR_W-1:0]           err_eff, err_fin;
  logic signed [REQ_W-1:0]           y, e_low;
  logic signed [8:0]                 err_frac;
  logic [psw_pkg::HOLD_W-1:0]        hold_fin;

  assign out_free = !out_valid_r || out_chan.ready;
  assign at_cap   = (wc_r >= CNT_W'(CAPACITY));
  assign is_long  = (req_r > psw_pkg::FULL_LIMIT_Q);
  assign err_eff  = head_i.restart ? '0 : err_r;

  // Final segment: round(req - 3) with halves up, and the leftover error
  always_comb begin
    y        = req_r - psw_pkg::ROUND_OFS_Q;
    e_low    = y - psw_pkg::HALF_Q;
    err_frac = $signed({1'b0, y[psw_pkg::FRAC_W-1:0]}) - 9'sd128;
    if (y[REQ_W-1]) begin
      hold_fin = '0;
      err_fin  = (e_low < psw_pkg::ERR_MIN_Q) ? ERR_W'(psw_pkg::ERR_MIN_Q)
                                             : e_low[ERR_W-1:0];
    end else begin
      hold_fin = y[psw_pkg::FRAC_W +: psw_pkg::HOLD_W];
      err_fin  = ERR_W'(err_frac);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    err_nxt       = err_r;
    wc_nxt        = wc_r;
    committed_nxt = committed_r;
    aborted_nxt   = aborted_r;
    req_nxt       = req_r;
    word_nxt      = word_r;
    eob_nxt       = eob_r;
    pop_o         = 1'b0;
    load_out      = 1'b0;
    o_hold        = '0;
    o_last        = 1'b0;
    o_full        = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (!q_empty_i) begin
          pop_o = 1'b1;
          if (head_i.restart) begin
            err_nxt     = '0;
            wc_nxt      = '0;
            aborted_nxt = 1'b0;
          end
          if (aborted_r && !head_i.restart) begin
            // drop items of an aborted write until it ends
            if (head_i.eob) begin
              wc_nxt      = committed_r;
              aborted_nxt = 1'b0;
            end
          end else begin
            req_nxt   = $signed(REQ_W'(head_i.duration)) + REQ_W'(err_eff);
            word_nxt  = head_i.word;
            eob_nxt   = head_i.eob;
            state_nxt = ST_RUN;
          end
        end
      end
      ST_RUN: begin
        if (out_free) begin
          load_out = 1'b1;
          if (at_cap) begin
            o_last    = 1'b1;
            o_full    = 1'b1;
            state_nxt = ST_IDLE;
            if (eob_r) begin
              wc_nxt = committed_r;
            end else begin
              aborted_nxt = 1'b1;
            end
          end else if (is_long) begin
            o_hold  = '1;
            wc_nxt  = wc_r + 1'b1;
            req_nxt = req_r - psw_pkg::FULL_COST_Q;
          end else begin
            o_hold    = hold_fin;
            o_last    = 1'b1;
            wc_nxt    = wc_r + 1'b1;
            err_nxt   = err_fin;
            state_nxt = ST_IDLE;
            if (eob_r) begin
              committed_nxt = wc_r + 1'b1;
            end
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      err_r       <= '0;
      wc_r        <= '0;
      committed_r <= '0;
      aborted_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      err_r       <= err_nxt;
      wc_r        <= wc_nxt;
      committed_r <= committed_nxt;
      aborted_r   <= aborted_nxt;
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r  <= req_nxt;
    word_r <= word_nxt;
    eob_r  <= eob_nxt;
    if (load_out) begin
      out_word_r <= word_r;
      out_hold_r <= o_hold;
      out_last_r <= o_last;
      out_full_r <= o_full;
    end
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.pattern_word  = out_word_r;
  assign out_chan.hold_ticks    = out_hold_r;
  assign out_chan.last_segment  = out_last_r;
  assign out_chan.capacity_full = out_full_r;

  a_wc_bound: assert property (@(posedge clk) disable iff (!rst_n)
    wc_r <= CNT_W'(CAPACITY))
    else $error("working count above capacity");

  a_commit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    committed_r <= CNT_W'(CAPACITY))
    else $error("committed count above capacity");

  a_run_not_aborted: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_RUN |-> !aborted_r)
    else $error("sequencer running during an aborted write");

  a_full_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_full_r |-> out_last_r && out_hold_r == '0)
    else $error("capacity result not final or carries ticks");

  a_abort_after_full: assert property (@(posedge clk) disable iff (!rst_n)
    load_out && o_full && !eob_r |=> aborted_r)
    else $error("capacity overflow did not mark the write aborted");

endmodule
`default_nettype wire

/* rtl/pattern_segment_writer_top.sv */
`default_nettype none
// Pattern segment writer. Each input transfer carries a logical word and a
// duration in Q37.8 ticks; the word is permuted onto pins through four
// programmable map registers (APB, byte address 8*i, identity after reset),
// and the duration plus the carried rounding error is cut into 0xFFFFFFFF-tick
// segments followed by one final rounded segment. A two-entry queue sits
// between the input side and the segment sequencer, so input transfers are
// taken while the sequencer works. The sequencer takes each item in a setup
// state, then one result per cycle while the output is not stalled. An item
// with k full-length segments gives k+1 results, one dropped in an aborted
// write none. A capacity_full result ends it once CAPACITY segments are stored.
module pattern_segment_writer_top #(
  parameter int CAPACITY = 1024,
  parameter int MAP_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  psw_in_if.sink                        in_chan,
  psw_out_if.source                     out_chan,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [psw_pkg::PADDR_W-1:0]   paddr,
  input  logic [psw_pkg::PDATA_W-1:0]   pwdata,
  output logic [psw_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int CNT_W = $clog2(CAPACITY + 1);

  psw_pkg::psw_map_t  map_r;
  logic [1:0]         reg_idx;
  logic               wr_en;
  logic               q_push, q_full, q_pop, q_empty;
  psw_pkg::psw_item_t q_in_item, q_head;

  assign reg_idx = paddr[psw_pkg::PADDR_W-1:3];
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;
  assign prdata  = psw_pkg::PDATA_W'(map_r[reg_idx]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < psw_pkg::MAP_REGS; i++) begin
        map_r[i] <= psw_pkg::map_default(i);
      end
    end else if (wr_en) begin
      map_r[reg_idx] <= pwdata[psw_pkg::MAP_REG_W-1:0];
    end
  end

  psw_front #(
    .MAP_BITS (MAP_BITS)
  ) u_front (
    .in_chan     (in_chan),
    .map_i       (map_r),
    .q_full_i    (q_full),
    .push_o      (q_push),
    .push_item_o (q_in_item)
  );

  psw_queue u_queue (
    .clk         (clk),
    .rst_n       (rst_n),
    .push_i      (q_push),
    .push_item_i (q_in_item),
    .full_o      (q_full),
    .pop_i       (q_pop),
    .head_o      (q_head),
    .empty_o     (q_empty)
  );

  psw_back #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty_i (q_empty),
    .head_i    (q_head),
    .pop_o     (q_pop),
    .out_chan  (out_chan)
  );

endmodule
`default_nettype wire

/* sim/psw_segment_check.sv */
`timescale 1ns / 100ps
module psw_segment_check #(
  parameter int CAPACITY = 1024,
  parameter int MAP_BITS = 32
) (
  input  logic                        clk,
  input  logic                        rst_n,
  psw_in_if                           in_chan,
  psw_out_if                          out_chan,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic                        pready,
  input  logic [psw_pkg::PADDR_W-1:0] paddr,
  input  logic [psw_pkg::PDATA_W-1:0] pwdata,
  output int unsigned                 mismatch_cnt,
  output int unsigned                 pending,
  output int unsigned                 live_items
);

  localparam longint FULL_LIMIT = 64'h0000_00FF_FFFF_FF00;
  localparam longint FULL_COST  = 64'h0000_0100_0000_0200;
  localparam longint OVERHEAD   = 768;
  localparam longint HALF_TICK  = 128;
  localparam longint ERR_HI     = (64'sd1 <<< 23) - 1;
  localparam longint ERR_LO     = -(64'sd1 <<< 23);

  typedef struct packed {
    logic [psw_pkg::WORD_W-1:0] word;
    logic [psw_pkg::HOLD_W-1:0] hold;
    logic                       last;
    logic                       full;
  } segment_t;

  segment_t                         segs_q [$];
  logic [psw_pkg::MAP_REG_W-1:0]    pin_map [psw_pkg::MAP_REGS];
  logic signed [psw_pkg::ERR_W-1:0] carry;
  int unsigned                      work_cnt;
  int unsigned                      commit_cnt;
  bit                               aborted;
  int unsigned                      live_total;

  task automatic flag_mismatch(input string msg);
    $display("MISMATCH @%0t: %s", $realtime, msg);
    mismatch_cnt++;
  endtask

  task automatic clear_state();
    for (int r = 0; r < psw_pkg::MAP_REGS; r++) begin
      for (int k = 0; k < psw_pkg::MAP_PER_REG; k++) begin
        pin_map[r][psw_pkg::PIN_W*k +: psw_pkg::PIN_W] =
          psw_pkg::PIN_W'(r * psw_pkg::MAP_PER_REG + k);
      end
    end
    carry      = '0;
    work_cnt   = 0;
    commit_cnt = 0;
    aborted    = 1'b0;
    segs_q.delete();
  endtask

  function automatic logic [psw_pkg::WORD_W-1:0] route_pins(
    input logic [psw_pkg::WORD_W-1:0] value);
    logic [psw_pkg::WORD_W-1:0] pins;
    logic [psw_pkg::PIN_W-1:0]  pin;
    pins = '0;
    for (int b = 0; b < MAP_BITS && b < psw_pkg::WORD_W; b++) begin
      pin = pin_map[b / psw_pkg::MAP_PER_REG]
                   [psw_pkg::PIN_W*(b % psw_pkg::MAP_PER_REG) +: psw_pkg::PIN_W];
      if (value[b]) pins[pin] = 1'b1;
    end
    return pins;
  endfunction

  task automatic predict_segments(input logic [psw_pkg::WORD_W-1:0] value,
                                  input logic [psw_pkg::DUR_W-1:0] dur,
                                  input logic rs, input logic eob);
    logic [psw_pkg::WORD_W-1:0] pins;
    logic [psw_pkg::HOLD_W-1:0] hold;
    longint                     req;
    longint                     x;
    longint                     err;
    bit                         no_room;
    pins = route_pins(value);
    if (rs) begin
      carry    = '0;
      work_cnt = 0;
      aborted  = 1'b0;
    end
    if (aborted) begin
      // dropped until the write ends; the end rolls back to the committed count
      if (eob) begin
        work_cnt = commit_cnt;
        aborted  = 1'b0;
      end
    end else begin
      live_total++;
      req     = longint'(dur) + longint'(carry);
      no_room = 1'b0;
      while (req > FULL_LIMIT && !no_room) begin
        if (work_cnt >= CAPACITY) begin
          no_room = 1'b1;
        end else begin
          segs_q.push_back(segment_t'{pins, '1, 1'b0, 1'b0});
          work_cnt++;
          req -= FULL_COST;
        end
      end
      if (work_cnt >= CAPACITY) no_room = 1'b1;
      if (no_room) begin
        // carry keeps its value from before the item
        segs_q.push_back(segment_t'{pins, '0, 1'b1, 1'b1});
        if (eob) work_cnt = commit_cnt;
        else aborted = 1'b1;
      end else begin
        x    = req - OVERHEAD + HALF_TICK;
        hold = (x < 0) ? '0 : psw_pkg::HOLD_W'(x >>> psw_pkg::FRAC_W);
        segs_q.push_back(segment_t'{pins, hold, 1'b1, 1'b0});
        work_cnt++;
        err = req - ((longint'(hold) + 3) <<< psw_pkg::FRAC_W);
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;
        carry = err[psw_pkg::ERR_W-1:0];
        if (eob) commit_cnt = work_cnt;
      end
    end
  endtask

  task automatic check_segment();
    segment_t want;
    if (segs_q.size() == 0) begin
      flag_mismatch($sformatf("result with nothing expected: word=%h hold=%h last=%b full=%b",
                              out_chan.pattern_word, out_chan.hold_ticks,
                              out_chan.last_segment, out_chan.capacity_full));
    end else begin
      want = segs_q.pop_front();
      if (out_chan.pattern_word !== want.word)
        flag_mismatch($sformatf("pattern_word %h, expected %h",
                                out_chan.pattern_word, want.word));
      if (out_chan.hold_ticks !== want.hold)
        flag_mismatch($sformatf("hold_ticks %h, expected %h", out_chan.hold_ticks, want.hold));
      if (out_chan.last_segment !== want.last)
        flag_mismatch($sformatf("last_segment %b, expected %b",
                                out_chan.last_segment, want.last));
      if (out_chan.capacity_full !== want.full)
        flag_mismatch($sformatf("capacity_full %b, expected %b",
                                out_chan.capacity_full, want.full));
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
    end else begin
      if (psel && penable && pwrite && pready && int'(paddr >> 3) < psw_pkg::MAP_REGS)
        pin_map[int'(paddr >> 3)] = pwdata[psw_pkg::MAP_REG_W-1:0];
      if (in_chan.valid && in_chan.ready)
        predict_segments(in_chan.raw_word, in_chan.duration_ticks,
                         in_chan.restart, in_chan.end_of_batch);
      if (out_chan.valid && out_chan.ready) check_segment();
    end
    pending    <= segs_q.size();
    live_items <= live_total;
  end

endmodule

/* sim/tb.sv */
`timescale 1ns / 100ps
module tb;

  localparam int          CAP             = 1024;
  localparam int unsigned PHASE_ITEMS     = 72;
  localparam int unsigned SETTLE_CYCLES   = 40;
  localparam int unsigned WATCHDOG_CYCLES = 2_000_000;
  localparam logic [psw_pkg::DUR_W-1:0] DUR_MAX   = '1;
  localparam logic [psw_pkg::DUR_W-1:0] FULL_EDGE = 45'h00FF_FFFF_FF00;

  logic                        clk = 1'b0;
  logic                        rst_n;
  logic                        psel;
  logic                        penable;
  logic                        pwrite;
  logic                        pready;
  logic [psw_pkg::PADDR_W-1:0] paddr;
  logic [psw_pkg::PDATA_W-1:0] pwdata;
  logic [psw_pkg::PDATA_W-1:0] prdata;
  int unsigned                 mismatch_cnt;
  int unsigned                 pending;
  int unsigned                 live_items;
  bit                          steady_src;
  bit                          steady_sink;
  int unsigned                 stall_left;
  int unsigned                 pace_cnt;

  psw_in_if  in_chan ();
  psw_out_if out_chan ();

  pattern_segment_writer_top #(.CAPACITY(CAP), .MAP_BITS(32)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  psw_segment_check #(.CAPACITY(CAP), .MAP_BITS(32)) seg_check (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_chan      (in_chan),
    .out_chan     (out_chan),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .pready       (pready),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .mismatch_cnt (mismatch_cnt),
    .pending      (pending),
    .live_items   (live_items)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // result side back-pressure: short stalls mostly, a few long ones, calm stretches
  always @(posedge clk) begin : sink_pacing
    int r;
    r = $urandom_range(99);
    pace_cnt <= pace_cnt + 1;
    if (pace_cnt % 300 == 0) steady_sink <= ($urandom_range(3) == 0);
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
      stall_left     <= 0;
    end else if (stall_left != 0) begin
      out_chan.ready <= 1'b0;
      stall_left     <= stall_left - 1;
    end else if (steady_sink || r < 70) begin
      out_chan.ready <= 1'b1;
    end else begin
      out_chan.ready <= 1'b0;
      stall_left     <= (r < 95) ? $urandom_range(2) : $urandom_range(30, 8);
    end
  end

  function automatic logic [psw_pkg::WORD_W-1:0] pick_word();
    int r;
    r = $urandom_range(99);
    if (r < 70) return $urandom;
    if (r < 80) return psw_pkg::WORD_W'(1) << $urandom_range(31);
    if (r < 90) return ~(psw_pkg::WORD_W'(1) << $urandom_range(31));
    return ($urandom_range(1) == 0) ? '0 : '1;
  endfunction

  function automatic logic [psw_pkg::DUR_W-1:0] pick_duration();
    int                        r;
    logic [psw_pkg::DUR_W-1:0] base;
    r = $urandom_range(99);
    if (r < 40) return psw_pkg::DUR_W'($urandom) & 45'hFF_FFFF;
    // up to four ticks, around the overhead: the final hold often clamps at zero
    if (r < 50) return psw_pkg::DUR_W'($urandom_range(1023));
    if (r < 65) begin
      base = FULL_EDGE + psw_pkg::DUR_W'($urandom_range(3)) * 45'h100_0000_0200;
      return base - 45'd2048 + psw_pkg::DUR_W'($urandom_range(4095));
    end
    if (r < 85) return psw_pkg::DUR_W'({$urandom, $urandom}) & 45'h3FF_FFFF_FFFF;
    return psw_pkg::DUR_W'({$urandom, $urandom});
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (steady_src || r < 65) return 0;
    if (r < 93) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // valid stays high across back-to-back transfers; drop it only for a gap
  task automatic send_pair(input logic [psw_pkg::WORD_W-1:0] value,
                           input logic [psw_pkg::DUR_W-1:0] dur,
                           input bit rs, input bit eob);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_chan.valid          <= 1'b1;
    in_chan.raw_word       <= value;
    in_chan.duration_ticks <= dur;
    in_chan.restart        <= rs;
    in_chan.end_of_batch   <= eob;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_chan.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // dropped items leave nothing to wait for, so let the block settle too
  task automatic write_maps(input psw_pkg::psw_map_t maps);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    for (int i = 0; i < psw_pkg::MAP_REGS; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= psw_pkg::PADDR_W'(i * 8);
      pwdata  <= psw_pkg::PDATA_W'(maps[i]);
      @(posedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  task automatic normal_write();
    int unsigned len;
    bit          lead_restart;
    bit          close;
    len          = $urandom_range(8, 1);
    lead_restart = ($urandom_range(3) != 0);
    close        = ($urandom_range(9) != 0);
    steady_src   = ($urandom_range(3) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_pair(pick_word(), pick_duration(),
                (i == 0) ? lead_restart : ($urandom_range(29) == 0),
                (i == len - 1) ? close : ($urandom_range(19) == 0));
    end
  endtask

  // long durations until the store fills; a few more pairs are then dropped
  task automatic heavy_write();
    int unsigned len;
    bit          close_by_eob;
    len          = $urandom_range(50, 45);
    close_by_eob = ($urandom_range(1) == 1);
    steady_src   = ($urandom_range(1) == 0);
    for (int unsigned i = 0; i < len; i++) begin
      send_pair(pick_word(), {2'b11, 43'({$urandom, $urandom})},
                (i == 0), (i == len - 1) && close_by_eob);
    end
    if (!close_by_eob) send_pair(pick_word(), pick_duration(), 1'b1, ($urandom_range(1) == 1));
  endtask

  initial begin : watchdog
    int unsigned cyc;
    cyc = 0;
    while (cyc < WATCHDOG_CYCLES) begin
      @(posedge clk);
      cyc++;
    end
    $display("** pattern_segment_writer_top: FAILED **");
    $finish;
  end

  initial begin : stimulus
    psw_pkg::psw_map_t maps;
    int                perm [32];
    int                j;
    int                tmp;
    int unsigned       phase_start;
    rst_n                  = 1'b0;
    psel                   = 1'b0;
    penable                = 1'b0;
    pwrite                 = 1'b0;
    paddr                  = '0;
    pwdata                 = '0;
    in_chan.valid          = 1'b0;
    in_chan.raw_word       = '0;
    in_chan.duration_ticks = '0;
    in_chan.restart        = 1'b0;
    in_chan.end_of_batch   = 1'b0;
    out_chan.ready         = 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // identity map after reset
    send_pair('0, '0, 1'b1, 1'b0);
    send_pair('1, DUR_MAX, 1'b0, 1'b0);
    send_pair(32'h0000_0001, 45'h6480, 1'b1, 1'b0);
    send_pair(32'h8000_0000, 45'h647F, 1'b0, 1'b0);
    send_pair(32'hAAAA_AAAA, FULL_EDGE, 1'b1, 1'b0);
    send_pair(32'h5555_5555, FULL_EDGE + 45'd1, 1'b1, 1'b0);
    send_pair(32'h0000_FFFF, 45'h300, 1'b0, 1'b1);
    send_pair(32'hFFFF_0000, 45'h3_E800, 1'b1, 1'b1);
    send_pair(32'h1234_5678, 45'd767, 1'b1, 1'b0);
    send_pair(32'hDEAD_BEEF, 45'h380, 1'b0, 1'b1);
    send_pair('0, DUR_MAX, 1'b0, 1'b1);
    send_pair(32'h7FFF_FFFF, FULL_EDGE + 45'h100_0000_0200, 1'b1, 1'b0);
    send_pair(32'hFFFF_FFFE, FULL_EDGE - 45'd1, 1'b0, 1'b1);
    send_pair(32'h0F0F_0F0F, 45'h280, 1'b0, 1'b1);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin
          for (int i = 0; i < 32; i++) perm[i] = i;
          for (int i = 31; i > 0; i--) begin
            j       = $urandom_range(i);
            tmp     = perm[i];
            perm[i] = perm[j];
            perm[j] = tmp;
          end
          for (int i = 0; i < 32; i++)
            maps[i / psw_pkg::MAP_PER_REG]
                [psw_pkg::PIN_W*(i % psw_pkg::MAP_PER_REG) +: psw_pkg::PIN_W] =
              psw_pkg::PIN_W'(perm[i]);
        end
        1: maps = '1;
        2: maps = '0;
        default: begin
          for (int i = 0; i < psw_pkg::MAP_REGS; i++)
            maps[i] = psw_pkg::MAP_REG_W'({$urandom, $urandom});
        end
      endcase
      write_maps(maps);
      phase_start = live_items;
      if (phase == 0) heavy_write();
      while (live_items - phase_start < PHASE_ITEMS) begin
        if ($urandom_range(11) == 0) heavy_write();
        else normal_write();
        // hold the sender until every result is out
        if ($urandom_range(24) == 0) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_cnt == 0 && pending == 0) begin
      $display("** pattern_segment_writer_top: PASSED **");
    end else begin
      $display("** pattern_segment_writer_top: FAILED **");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/psw_pkg.sv
rtl/psw_in_if.sv
rtl/psw_out_if.sv
rtl/psw_front.sv
rtl/psw_queue.sv
rtl/psw_back.sv
rtl/pattern_segment_writer_top.sv
sim/psw_segment_check.sv
sim/tb.sv
